@@ rtl/http_request_line_router_defines.svh @@
// Assertion macros for the HTTP request-line router.
// Included by every RTL file that carries concurrent checks; needs clk and rst_n in scope.
`ifndef HTTP_REQUEST_LINE_ROUTER_DEFINES_SVH
`define HTTP_REQUEST_LINE_ROUTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, quiet while in reset.
`define HRLR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while in reset.
`define HRLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HRLR_ASSERT_NOW(label, ante, cons, msg)
`define HRLR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/hrlr_pkg.sv @@
// Shared types, character constants, phase codes and literal lookups for the router.
// No dependencies.
package hrlr_pkg;

  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  // Parse phase codes
  localparam logic [2:0] PH_METHOD  = 3'd0;
  localparam logic [2:0] PH_GAP1    = 3'd1;
  localparam logic [2:0] PH_PATH    = 3'd2;
  localparam logic [2:0] PH_GAP2    = 3'd3;
  localparam logic [2:0] PH_VERSION = 3'd4;
  localparam logic [2:0] PH_HEADERS = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  // Match flag bit positions
  localparam int unsigned FB_GET     = 0;
  localparam int unsigned FB_ROOT    = 1;
  localparam int unsigned FB_METRICS = 2;
  localparam int unsigned FB_VER     = 3;

  localparam logic [3:0] FLAGS_ALL = 4'hF;
  localparam logic [3:0] POS_MAX   = 4'd15;

  localparam logic [3:0] LEN_GET     = 4'd3;
  localparam logic [3:0] LEN_ROOT    = 4'd1;
  localparam logic [3:0] LEN_METRICS = 4'd8;
  localparam logic [3:0] LEN_VER     = 4'd8;

  // Route codes
  localparam logic [1:0] RT_ROOT    = 2'd0;
  localparam logic [1:0] RT_METRICS = 2'd1;
  localparam logic [1:0] RT_NFOUND  = 2'd2;
  localparam logic [1:0] RT_BADVER  = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] route;
  } hrlr_res_t;

  // Characters of "GET"; positions beyond the literal return zero.
  function automatic logic [7:0] lit_get(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h47;
      4'd1:    ch = 8'h45;
      4'd2:    ch = 8'h54;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Characters of "/metrics"; also serves "/" at position zero.
  function automatic logic [7:0] lit_metrics(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h2F;
      4'd1:    ch = 8'h6D;
      4'd2:    ch = 8'h65;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h72;
      4'd5:    ch = 8'h69;
      4'd6:    ch = 8'h63;
      4'd7:    ch = 8'h73;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Characters of "HTTP/1.1".
  function automatic logic [7:0] lit_ver(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h48;
      4'd1:    ch = 8'h54;
      4'd2:    ch = 8'h54;
      4'd3:    ch = 8'h50;
      4'd4:    ch = 8'h2F;
      4'd5:    ch = 8'h31;
      4'd6:    ch = 8'h2E;
      4'd7:    ch = 8'h31;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/hrlr_parse.sv @@
// Input word register and per-byte request-line parser with its state registers.
// Depends on hrlr_pkg and the router defines header.
`include "http_request_line_router_defines.svh"

module hrlr_parse
  import hrlr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_new_connection,
  input  logic       can_take,
  output logic       fire,
  output hrlr_res_t  res
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_newc_r;

  logic [2:0] phase_r, phase_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [3:0] flags_r, flags_nxt;
  logic       lhc_r, lhc_nxt;

  assign fire     = s1_valid_r && can_take;
  assign in_ready = !s1_valid_r || can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_newc_r <= in_new_connection;
    end
  end

  always_comb begin
    logic [7:0] c;
    logic       is_sp;
    c         = s1_byte_r;
    is_sp     = (c == CHR_SPACE);
    phase_nxt = s1_newc_r ? PH_METHOD : phase_r;
    pos_nxt   = s1_newc_r ? 4'd0 : pos_r;
    flags_nxt = s1_newc_r ? FLAGS_ALL : flags_r;
    lhc_nxt   = s1_newc_r ? 1'b0 : lhc_r;
    res       = '0;

    if (phase_nxt >= PH_DONE || c == CHR_CR) begin
      // ignore
    end else if (c == CHR_LF) begin
      if (!lhc_nxt) begin
        res.valid = 1'b1;
        if (!(phase_nxt == PH_HEADERS && flags_nxt[FB_VER])) begin
          res.route = RT_BADVER;
        end else if (flags_nxt[FB_GET] && flags_nxt[FB_ROOT]) begin
          res.route = RT_ROOT;
        end else if (flags_nxt[FB_GET] && flags_nxt[FB_METRICS]) begin
          res.route = RT_METRICS;
        end else begin
          res.route = RT_NFOUND;
        end
        phase_nxt = PH_DONE;
      end else begin
        if (phase_nxt == PH_VERSION) begin
          if (pos_nxt != LEN_VER) flags_nxt[FB_VER] = 1'b0;
        end else if (phase_nxt < PH_VERSION) begin
          flags_nxt[FB_VER] = 1'b0;
        end
        phase_nxt = PH_HEADERS;
        lhc_nxt   = 1'b0;
      end
    end else begin
      lhc_nxt = 1'b1;
      if (phase_nxt < PH_HEADERS) begin
        if (phase_nxt == PH_GAP1 && !is_sp) begin
          phase_nxt = PH_PATH;
          pos_nxt   = 4'd0;
        end else if (phase_nxt == PH_GAP2 && !is_sp) begin
          phase_nxt = PH_VERSION;
          pos_nxt   = 4'd0;
        end

        if (phase_nxt == PH_METHOD) begin
          if (is_sp) begin
            if (pos_nxt != LEN_GET) flags_nxt[FB_GET] = 1'b0;
            phase_nxt = PH_GAP1;
          end else begin
            if (pos_nxt >= LEN_GET || lit_get(pos_nxt) != c) flags_nxt[FB_GET] = 1'b0;
            if (pos_nxt < POS_MAX) pos_nxt = pos_nxt + 4'd1;
          end
        end else if (phase_nxt == PH_PATH) begin
          if (is_sp) begin
            if (pos_nxt != LEN_ROOT) flags_nxt[FB_ROOT] = 1'b0;
            if (pos_nxt != LEN_METRICS) flags_nxt[FB_METRICS] = 1'b0;
            phase_nxt = PH_GAP2;
          end else begin
            if (pos_nxt >= LEN_ROOT || lit_metrics(pos_nxt) != c) flags_nxt[FB_ROOT] = 1'b0;
            if (pos_nxt >= LEN_METRICS || lit_metrics(pos_nxt) != c) begin
              flags_nxt[FB_METRICS] = 1'b0;
            end
            if (pos_nxt < POS_MAX) pos_nxt = pos_nxt + 4'd1;
          end
        end else if (phase_nxt == PH_VERSION) begin
          if (pos_nxt >= LEN_VER || lit_ver(pos_nxt) != c) flags_nxt[FB_VER] = 1'b0;
          if (pos_nxt < POS_MAX) pos_nxt = pos_nxt + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD;
      pos_r   <= 4'd0;
      flags_r <= FLAGS_ALL;
      lhc_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      flags_r <= flags_nxt;
      lhc_r   <= lhc_nxt;
    end
  end

  `HRLR_ASSERT_NOW(a_res_only_on_lf, fire && res.valid, s1_byte_r == CHR_LF, "route without newline")
  `HRLR_ASSERT_NEXT(a_done_after_res, fire && res.valid, phase_r == PH_DONE, "phase not done after route")
  `HRLR_ASSERT_NOW(a_quiet_when_done, fire && phase_r >= PH_DONE && !s1_newc_r, !res.valid, "route after done")

endmodule

@@ rtl/hrlr_out_reg.sv @@
// Result register for the route word, holding it until the consumer takes it.
// Depends on hrlr_pkg.
module hrlr_out_reg
  import hrlr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  hrlr_res_t  res,
  output logic       can_take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_route
);

  logic       valid_r;
  logic [1:0] route_r;

  assign can_take  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_route = route_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load && res.valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) route_r <= res.route;
  end

endmodule

@@ rtl/http_request_line_router.sv @@
// Top level of the HTTP request-line router: input word register, parser, result register.
// Depends on hrlr_pkg, hrlr_parse and hrlr_out_reg.
//
// The router takes one request byte per word and, once the header ends with an empty
// line, gives a single route word: 0 root page, 1 metrics page, 2 not found, 3 version
// not supported. Carriage returns are dropped; the first line is split into method,
// path and version at runs of spaces, and each field is matched against GET, "/" or
// "/metrics", and HTTP/1.1 as its characters stream past. Everything after the route
// is ignored until a word arrives with in_new_connection set, which clears the parse
// state before that byte is looked at. Throughput is one byte per clock while the output
// register has room: a byte is captured in an input register, parsed by a single pass of
// compare and phase logic, and any route lands in an output register. The only stall
// comes from the output register: while a route waits unread, the parser holds its byte
// and in_ready drops. No configuration, no memories, no clearing pass after reset.
module http_request_line_router
  import hrlr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_new_connection,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_route
);

  logic      can_take;
  logic      fire;
  hrlr_res_t res;

  // Byte register and parser; advance whenever the result register has room.
  hrlr_parse u_parse (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_new_connection (in_new_connection),
    .can_take          (can_take),
    .fire              (fire),
    .res               (res)
  );

  // Hold the route word until the consumer takes it.
  hrlr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_route (out_route)
  );

endmodule
